/* rtl/qlsf_pkg.sv */
// ----------------------------------------------------------------------------
// qlsf_pkg
// shared types, constants and fixed-point helpers of the quadratic fit
// ----------------------------------------------------------------------------
package qlsf_pkg;

    localparam int MAX_POINTS      = 1024;
    localparam int SOLVE_FRAC_BITS = 24;
    localparam int CNT_W           = $clog2(MAX_POINTS + 1);

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_SING = 2'd1;
    localparam logic [1:0] ST_DROP = 2'd2;

    typedef struct packed {
        logic signed [11:0] x_value;
        logic signed [11:0] y_value;
        logic               last_point;
    } t_in;

    typedef struct packed {
        logic signed [31:0] coef_a0;
        logic signed [31:0] coef_a1;
        logic signed [31:0] coef_a2;
        logic [1:0]         fit_status;
    } t_out;

    function automatic logic [63:0] mag64(input logic signed [63:0] v);
        return v[63] ? (64'd0 - 64'(v)) : 64'(v);
    endfunction

    function automatic logic signed [63:0] signed_of(input logic neg, input logic [63:0] mag);
        if (!neg) return $signed(mag);
        if (mag[63]) return {1'b1, 63'd0};
        return $signed(64'd0 - mag);
    endfunction

    function automatic logic signed [63:0] sat64(input logic neg, input logic big,
                                                 input logic [63:0] mag);
        logic [63:0] lim;
        logic [63:0] m;
        lim = neg ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
        m   = (big || mag > lim) ? lim : mag;
        return signed_of(neg, m);
    endfunction

    function automatic logic signed [63:0] sat_sub(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
        logic [64:0] d;
        d = {a[63], a} - {b[63], b};
        if (d[64] != d[63]) return d[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
        return $signed(d[63:0]);
    endfunction

    function automatic logic signed [63:0] load_fx(input logic signed [63:0] v,
                                                   input int frac);
        logic [63:0] m;
        m = mag64(v);
        if (SOLVE_FRAC_BITS >= frac) m = m << (SOLVE_FRAC_BITS - frac);
        else m = m >> (frac - SOLVE_FRAC_BITS);
        return signed_of(v[63], m);
    endfunction

    function automatic logic signed [31:0] to_q16(input logic signed [63:0] v);
        logic [63:0] m;
        logic [63:0] lim;
        logic signed [63:0] s;
        m   = mag64(v) >> (SOLVE_FRAC_BITS - 16);
        lim = v[63] ? 64'h8000_0000 : 64'h7FFF_FFFF;
        if (m > lim) m = lim;
        s = signed_of(v[63], m);
        return s[31:0];
    endfunction

endpackage

/* rtl/qlsf_mul.sv */
// ----------------------------------------------------------------------------
// qlsf_mul
// fixed-point 64x64 multiply from four 32x32 partial products, saturated
// ----------------------------------------------------------------------------
module qlsf_mul (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic signed [63:0] i_a,
    input  logic signed [63:0] i_b,
    output logic               o_done,
    output logic signed [63:0] o_res
);
    import qlsf_pkg::*;

    logic [63:0]  r_ma;
    logic [63:0]  r_mb;
    logic         r_neg;
    logic [127:0] r_acc;
    logic [2:0]   r_step;
    logic         r_busy;
    logic         r_done;
    logic signed [63:0] r_res;

    logic [31:0]  op_a;
    logic [31:0]  op_b;
    logic [63:0]  pp;
    logic [1:0]   sh_sel;
    logic [127:0] acc_sh;

    assign op_a   = r_step[1] ? r_ma[63:32] : r_ma[31:0];
    assign op_b   = r_step[0] ? r_mb[63:32] : r_mb[31:0];
    assign pp     = op_a * op_b;
    assign sh_sel = 2'(r_step[1]) + 2'(r_step[0]);
    assign acc_sh = r_acc >> SOLVE_FRAC_BITS;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_ma   <= mag64(i_a);
                r_mb   <= mag64(i_b);
                r_neg  <= i_a[63] != i_b[63];
                r_acc  <= '0;
                r_step <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                if (r_step == 3'd4) begin
                    r_res  <= sat64(r_neg, acc_sh[127:64] != 64'd0, acc_sh[63:0]);
                    r_done <= 1'b1;
                    r_busy <= 1'b0;
                end else begin
                    r_acc  <= r_acc + (128'(pp) << {sh_sel, 5'd0});
                    r_step <= r_step + 3'd1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_res  = r_res;

endmodule

/* rtl/qlsf_div.sv */
// ----------------------------------------------------------------------------
// qlsf_div
// fixed-point 64-bit divide, restoring, one quotient bit per cycle, saturated
// ----------------------------------------------------------------------------
module qlsf_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic signed [63:0] i_a,
    input  logic signed [63:0] i_b,
    output logic               o_done,
    output logic signed [63:0] o_res
);
    import qlsf_pkg::*;

    logic [63:0] r_rem;
    logic [63:0] r_lo;
    logic [63:0] r_q;
    logic [63:0] r_d;
    logic        r_neg;
    logic [6:0]  r_cnt;
    logic        r_busy;
    logic        r_done;
    logic signed [63:0] r_res;

    logic [63:0] ma;
    logic [63:0] md;
    logic [63:0] hi;
    logic [63:0] rem2;
    logic        take;

    assign ma   = mag64(i_a);
    assign md   = mag64(i_b);
    assign hi   = ma >> (64 - SOLVE_FRAC_BITS);
    assign rem2 = {r_rem[62:0], r_lo[63]};
    assign take = r_rem[63] || (rem2 >= r_d);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_neg <= i_a[63] != i_b[63];
                r_d   <= md;
                r_rem <= hi;
                r_lo  <= ma << SOLVE_FRAC_BITS;
                r_q   <= '0;
                r_cnt <= 7'd64;
                if (hi >= md) begin
                    r_res  <= sat64(i_a[63] != i_b[63], 1'b1, 64'd0);
                    r_done <= 1'b1;
                end else begin
                    r_busy <= 1'b1;
                end
            end else if (r_busy) begin
                if (r_cnt == 7'd0) begin
                    r_res  <= sat64(r_neg, 1'b0, r_q);
                    r_done <= 1'b1;
                    r_busy <= 1'b0;
                end else begin
                    r_rem <= take ? rem2 - r_d : rem2;
                    r_q   <= {r_q[62:0], take};
                    r_lo  <= {r_lo[62:0], 1'b0};
                    r_cnt <= r_cnt - 7'd1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_res  = r_res;

endmodule

/* rtl/quadratic_least_squares_fit.sv */
// ----------------------------------------------------------------------------
// quadratic_least_squares_fit
// accumulates (x,y) moments and solves y = a0 + a1*x + a2*x^2 on the last item
// ----------------------------------------------------------------------------
// input channel: i_in_valid/o_in_ready carry one point (Q6.6 x and y, last
// flag). output channel: o_out_valid/i_out_ready carry three Q16.16
// coefficients and a status, one result per item flagged last.
// one 36x12 multiplier forms x^2, xy, x^2y, x^3 and x^4 of a point in five
// steps after the accept cycle; points beyond capacity skip these steps.
// the last point then starts the solve: the 3x4 matrix is loaded, then
// Gauss-Jordan elimination runs on a matrix memory with one read and one
// write port, a bit-serial divider and a four-partial-product multiplier;
// it needs at most 6 ratios, each applied to 4 columns, and 3 final divides.
// reset clears the count, sums and drop flag and leaves no result pending.
// a result waits in the output register while new points are accepted; a
// solve that finishes while the receiver stalls holds until it is taken.
// ----------------------------------------------------------------------------
module quadratic_least_squares_fit (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  qlsf_pkg::t_in  i_in,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output qlsf_pkg::t_out o_out
);
    import qlsf_pkg::*;

    localparam logic [4:0] S_IDLE    = 5'd0;
    localparam logic [4:0] S_ACC0    = 5'd1;
    localparam logic [4:0] S_ACC1    = 5'd2;
    localparam logic [4:0] S_ACC2    = 5'd3;
    localparam logic [4:0] S_ACC3    = 5'd4;
    localparam logic [4:0] S_ACC4    = 5'd5;
    localparam logic [4:0] S_LOAD    = 5'd6;
    localparam logic [4:0] S_PIV_RD  = 5'd7;
    localparam logic [4:0] S_PIV_CK  = 5'd8;
    localparam logic [4:0] S_RAT_RD  = 5'd9;
    localparam logic [4:0] S_RAT_GO  = 5'd10;
    localparam logic [4:0] S_RAT_W   = 5'd11;
    localparam logic [4:0] S_COL_RD  = 5'd12;
    localparam logic [4:0] S_COL_MUL = 5'd13;
    localparam logic [4:0] S_MUL_W   = 5'd14;
    localparam logic [4:0] S_FIN_RD  = 5'd15;
    localparam logic [4:0] S_FIN_CK  = 5'd16;
    localparam logic [4:0] S_FIN_RD2 = 5'd17;
    localparam logic [4:0] S_FIN_GO  = 5'd18;
    localparam logic [4:0] S_FIN_W   = 5'd19;
    localparam logic [4:0] S_OUT     = 5'd20;

    logic [4:0] r_state;
    logic [4:0] n_state;

    logic signed [11:0] r_x;
    logic signed [11:0] r_y;
    logic               r_last;
    logic signed [35:0] r_pw;
    logic signed [63:0] r_sum [7];
    logic [CNT_W-1:0]   r_count;
    logic               r_ovf;

    logic [3:0]  r_k;
    logic [1:0]  r_op;
    logic [1:0]  r_row;
    logic [1:0]  r_col;
    logic        r_sing;
    logic signed [63:0] r_piv;
    logic signed [63:0] r_ratio;
    logic signed [31:0] r_coef [3];

    logic [63:0] r_mat [12];
    logic signed [63:0] r_rd;
    logic [3:0]  raddr;
    logic [3:0]  waddr;
    logic        we;
    logic signed [63:0] wdata;
    logic signed [63:0] load_val;

    logic               r_out_valid;
    t_out               r_out;

    logic signed [35:0] m_a;
    logic signed [11:0] m_b;
    logic signed [47:0] m_p;

    logic               mul_done;
    logic signed [63:0] mul_res;
    logic               div_done;
    logic signed [63:0] div_res;
    logic               accept;
    logic               out_free;
    logic [2:0]         nrow;
    logic [1:0]         first_row;

    assign accept   = i_in_valid && o_in_ready;
    assign out_free = !r_out_valid || i_out_ready;
    assign o_in_ready = r_state == S_IDLE;

    // next elimination row, skipping the pivot row
    always_comb begin
        nrow = 3'(r_row) + 3'd1;
        if (nrow[1:0] == r_op && nrow != 3'd3) nrow = nrow + 3'd1;
    end
    assign first_row = (r_op == 2'd0) ? 2'd1 : 2'd0;

    // shared moment multiplier
    always_comb begin
        case (r_state)
            S_ACC0:  begin m_a = 36'(r_x); m_b = r_x; end
            S_ACC1:  begin m_a = 36'(r_x); m_b = r_y; end
            S_ACC2:  begin m_a = r_pw;     m_b = r_y; end
            default: begin m_a = r_pw;     m_b = r_x; end
        endcase
    end
    assign m_p = m_a * m_b;

    always_comb begin
        unique case (r_k)
            4'd0:             load_val = load_fx($signed(64'(r_count)), 0);
            4'd1, 4'd4:       load_val = load_fx(r_sum[0], 6);
            4'd2, 4'd5, 4'd8: load_val = load_fx(r_sum[1], 12);
            4'd3:             load_val = load_fx(r_sum[4], 6);
            4'd6, 4'd9:       load_val = load_fx(r_sum[2], 18);
            4'd7:             load_val = load_fx(r_sum[5], 12);
            4'd10:            load_val = load_fx(r_sum[3], 24);
            4'd11:            load_val = load_fx(r_sum[6], 18);
            default:          load_val = '0;
        endcase
    end

    always_comb begin
        raddr = 4'(r_row) * 4'd4 + 4'(r_col);
        unique case (r_state)
            S_PIV_RD:  raddr = 4'(r_op) * 4'd5;
            S_RAT_RD:  raddr = 4'(r_row) * 4'd4 + 4'(r_op);
            S_COL_RD:  raddr = 4'(r_op) * 4'd4 + 4'(r_col);
            S_FIN_RD:  raddr = 4'(r_row) * 4'd5;
            S_FIN_RD2: raddr = 4'(r_row) * 4'd4 + 4'd3;
            default:   raddr = 4'(r_row) * 4'd4 + 4'(r_col);
        endcase
    end

    assign we    = (r_state == S_LOAD) || (r_state == S_MUL_W && mul_done);
    assign waddr = (r_state == S_LOAD) ? r_k : 4'(r_row) * 4'd4 + 4'(r_col);
    assign wdata = (r_state == S_LOAD) ? load_val : sat_sub(r_rd, mul_res);

    always_ff @(posedge i_clk) begin
        if (we) r_mat[waddr] <= wdata;
        r_rd <= $signed(r_mat[raddr]);
    end

    qlsf_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == S_COL_MUL),
        .i_a     (r_ratio),
        .i_b     (r_rd),
        .o_done  (mul_done),
        .o_res   (mul_res)
    );

    qlsf_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start ((r_state == S_RAT_GO) || (r_state == S_FIN_GO)),
        .i_a     (r_rd),
        .i_b     (r_piv),
        .o_done  (div_done),
        .o_res   (div_res)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (r_count < CNT_W'(MAX_POINTS)) n_state = S_ACC0;
                    else if (i_in.last_point)         n_state = S_LOAD;
                end
            end
            S_ACC0:    n_state = S_ACC1;
            S_ACC1:    n_state = S_ACC2;
            S_ACC2:    n_state = S_ACC3;
            S_ACC3:    n_state = S_ACC4;
            S_ACC4:    n_state = r_last ? S_LOAD : S_IDLE;
            S_LOAD:    if (r_k == 4'd11) n_state = S_PIV_RD;
            S_PIV_RD:  n_state = S_PIV_CK;
            S_PIV_CK:  n_state = (r_rd == 64'sd0) ? S_OUT : S_RAT_RD;
            S_RAT_RD:  n_state = S_RAT_GO;
            S_RAT_GO:  n_state = S_RAT_W;
            S_RAT_W:   if (div_done) n_state = S_COL_RD;
            S_COL_RD:  n_state = S_COL_MUL;
            S_COL_MUL: n_state = S_MUL_W;
            S_MUL_W: begin
                if (mul_done) begin
                    if (r_col != 2'd3)     n_state = S_COL_RD;
                    else if (nrow != 3'd3) n_state = S_RAT_RD;
                    else if (r_op != 2'd2) n_state = S_PIV_RD;
                    else                   n_state = S_FIN_RD;
                end
            end
            S_FIN_RD:  n_state = S_FIN_CK;
            S_FIN_CK:  n_state = (r_rd == 64'sd0) ? S_OUT : S_FIN_RD2;
            S_FIN_RD2: n_state = S_FIN_GO;
            S_FIN_GO:  n_state = S_FIN_W;
            S_FIN_W:   if (div_done) n_state = (r_row == 2'd2) ? S_OUT : S_FIN_RD;
            S_OUT:     if (out_free) n_state = S_IDLE;
            default:   n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
            r_sing      <= 1'b0;
            r_k         <= '0;
            r_op        <= '0;
            r_row       <= '0;
            r_col       <= '0;
            for (int i = 0; i < 7; i++) r_sum[i] <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == S_OUT && out_free) r_out_valid <= 1'b1;
            else if (r_out_valid && i_out_ready) r_out_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    r_x    <= i_in.x_value;
                    r_y    <= i_in.y_value;
                    r_last <= i_in.last_point;
                    r_k    <= '0;
                    r_sing <= 1'b0;
                    if (accept && r_count >= CNT_W'(MAX_POINTS)) r_ovf <= 1'b1;
                end
                S_ACC0: begin
                    r_pw     <= 36'(m_p);
                    r_sum[0] <= r_sum[0] + 64'(r_x);
                    r_sum[4] <= r_sum[4] + 64'(r_y);
                    r_count  <= r_count + CNT_W'(1);
                end
                S_ACC1: begin
                    r_sum[5] <= r_sum[5] + 64'(m_p);
                    r_sum[1] <= r_sum[1] + 64'(r_pw);
                end
                S_ACC2: r_sum[6] <= r_sum[6] + 64'(m_p);
                S_ACC3: begin
                    r_sum[2] <= r_sum[2] + 64'(m_p);
                    r_pw     <= 36'(m_p);
                end
                S_ACC4: r_sum[3] <= r_sum[3] + 64'(m_p);
                S_LOAD: begin
                    r_k  <= r_k + 4'd1;
                    r_op <= '0;
                    r_row <= 2'd1;
                end
                S_PIV_CK: begin
                    r_piv <= r_rd;
                    r_row <= first_row;
                    if (r_rd == 64'sd0) r_sing <= 1'b1;
                end
                S_RAT_W: begin
                    if (div_done) begin
                        r_ratio <= div_res;
                        r_col   <= '0;
                    end
                end
                S_MUL_W: begin
                    if (mul_done) begin
                        r_col <= r_col + 2'd1;
                        if (r_col == 2'd3) begin
                            if (nrow != 3'd3) begin
                                r_row <= nrow[1:0];
                            end else begin
                                r_op  <= r_op + 2'd1;
                                r_row <= '0;
                            end
                        end
                    end
                end
                S_FIN_CK: begin
                    r_piv <= r_rd;
                    if (r_rd == 64'sd0) r_sing <= 1'b1;
                end
                S_FIN_W: begin
                    if (div_done) begin
                        r_coef[r_row] <= to_q16(div_res);
                        r_row <= r_row + 2'd1;
                    end
                end
                S_OUT: begin
                    if (out_free) begin
                        r_out.coef_a0 <= r_sing ? 32'sd0 : r_coef[0];
                        r_out.coef_a1 <= r_sing ? 32'sd0 : r_coef[1];
                        r_out.coef_a2 <= r_sing ? 32'sd0 : r_coef[2];
                        r_out.fit_status <= r_sing ? ST_SING : (r_ovf ? ST_DROP : ST_OK);
                        r_count <= '0;
                        r_ovf   <= 1'b0;
                        for (int i = 0; i < 7; i++) r_sum[i] <= '0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_POINTS))
        else $error("point count beyond capacity");

    a_sing_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.fit_status == ST_SING) |->
        (r_out.coef_a0 == 32'sd0 && r_out.coef_a1 == 32'sd0 && r_out.coef_a2 == 32'sd0))
        else $error("singular result with nonzero coefficients");

    a_mul_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mul_done |-> r_state == S_MUL_W)
        else $error("multiplier finished outside its wait state");

    a_div_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == S_RAT_W || r_state == S_FIN_W))
        else $error("divider finished outside its wait state");

endmodule

/* verif/tb_quadratic_least_squares_fit.sv */
// ----------------------------------------------------------------------------
// tb_quadratic_least_squares_fit
// self-checking bench for the streaming quadratic least-squares fit
// ----------------------------------------------------------------------------
// points are sent over the valid/ready input in random bursts and each set
// ends with a point flagged last. a bit-exact fixed-point fit predictor in
// the bench forms the expected coefficients and status, which are compared
// field by field with every result taken from the output channel. the
// receiver stalls on its own pattern and once holds off for a long stretch
// so that the block fills up and back-pressures its input.
// ----------------------------------------------------------------------------
module tb_quadratic_least_squares_fit;

    timeunit 1ns;
    timeprecision 1ps;

    import qlsf_pkg::*;

    localparam int FB = SOLVE_FRAC_BITS;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic o_in_ready;
    t_in  i_in = '0;
    logic o_out_valid;
    logic i_out_ready = 1'b0;
    t_out o_out;

    quadratic_least_squares_fit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

    always #4 i_clk = ~i_clk;

    t_out fit_expect_q[$];
    int   fail_count;
    int   points_sent;
    int   fits_checked;
    int   burst_left;
    bit   long_stall_req;

    int          set_count;
    longint      moment[7];
    bit          dropped;

    function automatic logic [63:0] magnitude(input longint v);
        return v < 0 ? 64'd0 - 64'(v) : 64'(v);
    endfunction

    function automatic longint with_sign(input bit neg, input logic [63:0] m);
        if (!neg) return longint'(m);
        if (m[63]) return {1'b1, 63'd0};
        return longint'(64'd0 - m);
    endfunction

    function automatic longint clamp_wide(input bit neg, input logic [127:0] m);
        logic [63:0] lim;
        lim = neg ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
        if (|m[127:64] || m[63:0] > lim) return with_sign(neg, lim);
        return with_sign(neg, m[63:0]);
    endfunction

    function automatic longint fx_product(input longint a, input longint b);
        logic [127:0] p;
        p = {64'd0, magnitude(a)} * {64'd0, magnitude(b)};
        return clamp_wide((a < 0) != (b < 0), p >> FB);
    endfunction

    function automatic longint fx_quotient(input longint a, input longint b);
        logic [127:0] n;
        n = {64'd0, magnitude(a)} << FB;
        return clamp_wide((a < 0) != (b < 0), n / {64'd0, magnitude(b)});
    endfunction

    function automatic longint clamp_sub(input longint a, input longint b);
        logic [64:0] d;
        d = {a[63], a} - {b[63], b};
        if (d[64] != d[63]) return d[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
        return longint'(d[63:0]);
    endfunction

    function automatic longint rescale(input longint v, input int frac);
        logic [63:0] m;
        m = magnitude(v);
        m = (FB >= frac) ? m << (FB - frac) : m >> (frac - FB);
        return with_sign(v < 0, m);
    endfunction

    function automatic logic signed [31:0] q16_of(input longint v);
        logic [63:0] m;
        logic [63:0] lim;
        longint      s;
        m   = magnitude(v) >> (FB - 16);
        lim = v < 0 ? 64'h8000_0000 : 64'h7FFF_FFFF;
        if (m > lim) m = lim;
        s = with_sign(v < 0, m);
        return s[31:0];
    endfunction

    function automatic t_out solve_fit();
        longint m[12];
        longint coef[3];
        longint ratio;
        t_out   r;
        bit     ok;
        ok    = 1;
        m[0]  = rescale(longint'(set_count), 0);
        m[1]  = rescale(moment[0], 6);
        m[2]  = rescale(moment[1], 12);
        m[3]  = rescale(moment[4], 6);
        m[4]  = m[1];
        m[5]  = m[2];
        m[6]  = rescale(moment[2], 18);
        m[7]  = rescale(moment[5], 12);
        m[8]  = m[2];
        m[9]  = m[6];
        m[10] = rescale(moment[3], 24);
        m[11] = rescale(moment[6], 18);
        for (int op = 0; op < 3 && ok; op++) begin
            if (m[op*4+op] == 0) begin
                ok = 0;
            end else begin
                for (int row = 0; row < 3; row++) begin
                    if (row != op) begin
                        ratio = fx_quotient(m[row*4+op], m[op*4+op]);
                        for (int col = 0; col < 4; col++)
                            m[row*4+col] = clamp_sub(m[row*4+col],
                                                     fx_product(ratio, m[op*4+col]));
                    end
                end
            end
        end
        for (int row = 0; row < 3 && ok; row++) begin
            if (m[row*4+row] == 0) ok = 0;
            else coef[row] = fx_quotient(m[row*4+3], m[row*4+row]);
        end
        if (!ok) begin
            r = '0;
            r.fit_status = ST_SING;
        end else begin
            r.coef_a0 = q16_of(coef[0]);
            r.coef_a1 = q16_of(coef[1]);
            r.coef_a2 = q16_of(coef[2]);
            r.fit_status = dropped ? ST_DROP : ST_OK;
        end
        return r;
    endfunction

    task automatic accumulate_point(input t_in p);
        longint x;
        longint y;
        x = p.x_value;
        y = p.y_value;
        if (set_count < MAX_POINTS) begin
            moment[0] += x;
            moment[1] += x * x;
            moment[2] += x * x * x;
            moment[3] += x * x * x * x;
            moment[4] += y;
            moment[5] += x * y;
            moment[6] += x * x * y;
            set_count++;
        end else begin
            dropped = 1;
        end
        if (p.last_point) begin
            fit_expect_q.push_back(solve_fit());
            set_count = 0;
            dropped = 0;
            for (int i = 0; i < 7; i++) moment[i] = 0;
        end
    endtask

    task automatic send_point(input int x, input int y, input bit last);
        t_in p;
        p.x_value = x[11:0];
        p.y_value = y[11:0];
        p.last_point = last;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            if ($urandom_range(0, 2) != 0) begin
                i_in_valid <= 1'b0;
                repeat ($urandom_range(1, 7)) @(posedge i_clk);
            end
        end
        burst_left--;
        i_in_valid <= 1'b1;
        i_in <= p;
        forever begin
            @(negedge i_clk);
            if (o_in_ready) break;
        end
        @(posedge i_clk);
        accumulate_point(p);
        points_sent++;
    endtask

    task automatic idle_input();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch on fit %0d: %s got %0d expected %0d", fits_checked, what, got, want);
        fail_count++;
    endtask

    // output side checker, values sampled mid-cycle before the accepting edge
    always @(negedge i_clk) begin
        t_out want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (fit_expect_q.size() == 0) begin
                report_mismatch("unexpected result, status", o_out.fit_status, -1);
            end else begin
                want = fit_expect_q.pop_front();
                if (o_out.coef_a0 !== want.coef_a0)
                    report_mismatch("coef_a0", o_out.coef_a0, want.coef_a0);
                if (o_out.coef_a1 !== want.coef_a1)
                    report_mismatch("coef_a1", o_out.coef_a1, want.coef_a1);
                if (o_out.coef_a2 !== want.coef_a2)
                    report_mismatch("coef_a2", o_out.coef_a2, want.coef_a2);
                if (o_out.fit_status !== want.fit_status)
                    report_mismatch("fit_status", o_out.fit_status, want.fit_status);
            end
            fits_checked++;
        end
    end

    // receiver stall pattern plus one long hold-off on request
    initial begin
        int hold;
        int mode;
        int phase;
        hold = 0;
        mode = 0;
        phase = 0;
        forever begin
            @(posedge i_clk);
            if (long_stall_req) begin
                long_stall_req = 0;
                hold = 4000;
            end
            if (phase == 0) begin
                mode = $urandom_range(0, 3);
                phase = $urandom_range(20, 300);
            end
            phase--;
            if (hold > 0) begin
                hold--;
                i_out_ready <= 1'b0;
            end else begin
                case (mode)
                    0: i_out_ready <= 1'b1;
                    1: i_out_ready <= $urandom_range(0, 1);
                    2: i_out_ready <= (phase % 8) < 2;
                    default: i_out_ready <= ($urandom_range(0, 9) == 0);
                endcase
            end
        end
    end

    task automatic test_corners();
        send_point(-2048, -2048, 0);
        send_point(2047, 2047, 0);
        send_point(0, -2048, 0);
        send_point(-2048, 2047, 0);
        send_point(2047, -2048, 1);
    endtask

    task automatic test_single_point();
        send_point(100, 200, 1);
    endtask

    task automatic test_repeated_x();
        send_point(64, 10, 0);
        send_point(64, -300, 0);
        send_point(64, 900, 1);
    endtask

    task automatic test_exact_parabola();
        for (int i = -2; i <= 2; i++) send_point(i * 64, 64 + 32 * i + 16 * i * i, i == 2);
    endtask

    task automatic test_steep_line();
        send_point(0, -2048, 0);
        send_point(1, 0, 0);
        send_point(2, 2047, 1);
    endtask

    task automatic test_backpressure();
        long_stall_req = 1;
        for (int s = 0; s < 4; s++)
            for (int i = 0; i < 4; i++)
                send_point($urandom_range(0, 4095) - 2048, $urandom_range(0, 4095) - 2048,
                           i == 3);
    endtask

    task automatic test_random_sets();
        int n;
        int sent;
        int span;
        sent = 0;
        while (sent < 515) begin
            n = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 3) : $urandom_range(3, 12);
            span = ($urandom_range(0, 1) == 0) ? 2048 : $urandom_range(8, 256);
            for (int i = 0; i < n; i++) begin
                send_point($urandom_range(0, 2 * span - 1) - span,
                           $urandom_range(0, 4095) - 2048, i == n - 1);
                sent++;
            end
            if ($urandom_range(0, 9) == 0) idle_input();
        end
    endtask

    initial begin
        int waited;
        fail_count = 0;
        points_sent = 0;
        fits_checked = 0;
        burst_left = 0;
        long_stall_req = 0;
        set_count = 0;
        dropped = 0;
        for (int i = 0; i < 7; i++) moment[i] = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_corners();
        test_single_point();
        test_repeated_x();
        test_exact_parabola();
        test_steep_line();
        test_backpressure();
        test_random_sets();
        i_in_valid <= 1'b0;
        waited = 0;
        while (fit_expect_q.size() != 0 && waited < 200000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (50) @(posedge i_clk);
        if (fit_expect_q.size() != 0) begin
            $display("%0d expected results never arrived", fit_expect_q.size());
            fail_count++;
        end
        $display("sent %0d points, checked %0d fits across corners, singular sets,",
                 points_sent, fits_checked);
        $display("a long output stall and random sets");
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("Test completed with failures");
        $finish;
    end

endmodule
